@@ hdl/sprg_pkg.sv @@
package sprg_pkg;

    localparam int unsigned CompareWidth = 12;
    localparam int unsigned AngleWidth   = 8;
    localparam int unsigned HoldWidth    = 16;
    localparam int unsigned StepWidth    = 8;
    localparam int unsigned TickWidth    = 4;

    localparam logic [TickWidth-1:0]    STEP_TICKS  = 4'd10;
    localparam logic [AngleWidth-1:0]   MAX_ANGLE   = 8'd180;
    localparam logic [CompareWidth-1:0] MIN_COMPARE = 12'd500;
    localparam logic [CompareWidth-1:0] MAX_COMPARE = 12'd2500;

    // 2000/180 = 100/9 scaled by 2^16, rounded up; exact for angles 0..180
    localparam int unsigned MapShift = 16;
    localparam logic [19:0] MAP_RECIP = 20'd728178;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RAMP = 2'd1,
        PH_HOLD = 2'd2
    } t_phase;

    typedef struct packed {
        logic                    cmd;
        logic [AngleWidth-1:0]   angle_deg;
        logic [HoldWidth-1:0]    hold_ms;
        logic [StepWidth-1:0]    step_size;
    } t_item;

    typedef struct packed {
        logic [CompareWidth-1:0] pulse_compare;
        logic                    busy_res;
        logic                    rejected;
    } t_result;

    // one saturating step of cur toward goal
    function automatic logic [CompareWidth-1:0] f_take_step(
        input logic [CompareWidth-1:0] cur,
        input logic [CompareWidth-1:0] goal,
        input logic [StepWidth-1:0]    step
    );
        logic [CompareWidth-1:0] diff;
        logic [CompareWidth-1:0] step_ext;
        logic [CompareWidth-1:0] res;
        step_ext = {{(CompareWidth-StepWidth){1'b0}}, step};
        res = cur;
        if (cur < goal) begin
            diff = goal - cur;
            res  = (diff < step_ext) ? goal : cur + step_ext;
        end else begin
            diff = cur - goal;
            if (cur != goal) begin
                res = (diff < step_ext) ? goal : cur - step_ext;
            end
        end
        return res;
    endfunction

endpackage

@@ hdl/servo_pulse_ramp_generator_core.sv @@
// Servo pulse ramp generator: each transaction is a 1 ms tick or a move request and yields
// one result with the compare value, the busy flag and a reject flag. One transaction is
// taken every clock cycle while the output is not stalled; it passes through the input
// register, then the state update into the result register. The result register lets the next
// transaction enter while a result waits for i_out_ready.
module servo_pulse_ramp_generator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [sprg_pkg::AngleWidth-1:0]   i_angle_deg,
    input  logic [sprg_pkg::HoldWidth-1:0]    i_hold_ms,
    input  logic [sprg_pkg::StepWidth-1:0]    i_step_size,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sprg_pkg::CompareWidth-1:0] o_pulse_compare,
    output logic                              o_busy_res,
    output logic                              o_rejected
);

    logic              r_in_valid, n_in_valid;
    sprg_pkg::t_item   r_item;
    logic              r_out_valid, n_out_valid;
    sprg_pkg::t_result r_result;
    sprg_pkg::t_result result;
    logic              advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign n_in_valid  = (i_in_valid && o_in_ready) || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && !i_out_ready);

    sprg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_apply  (advance),
        .i_item   (r_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.cmd       <= i_cmd;
            r_item.angle_deg <= i_angle_deg;
            r_item.hold_ms   <= i_hold_ms;
            r_item.step_size <= i_step_size;
        end
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pulse_compare = r_result.pulse_compare;
    assign o_busy_res      = r_result.busy_res;
    assign o_rejected      = r_result.rejected;

endmodule

@@ hdl/sprg_angle_map.sv @@
module sprg_angle_map (
    input  logic [sprg_pkg::AngleWidth-1:0]   i_angle,
    output logic [sprg_pkg::CompareWidth-1:0] o_compare
);

    logic [sprg_pkg::AngleWidth-1:0] angle_clamped;
    logic [27:0]                     product;

    assign angle_clamped = (i_angle > sprg_pkg::MAX_ANGLE) ? sprg_pkg::MAX_ANGLE : i_angle;
    assign product = 28'(angle_clamped) * 28'(sprg_pkg::MAP_RECIP);
    assign o_compare = sprg_pkg::MIN_COMPARE
                     + product[sprg_pkg::MapShift +: sprg_pkg::CompareWidth];

endmodule

@@ hdl/sprg_ctrl.sv @@
module sprg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_apply,
    input  sprg_pkg::t_item   i_item,
    output sprg_pkg::t_result o_result
);

    logic [sprg_pkg::CompareWidth-1:0] r_cur, n_cur;
    logic [sprg_pkg::CompareWidth-1:0] r_goal, n_goal;
    logic [sprg_pkg::StepWidth-1:0]    r_step, n_step;
    logic [sprg_pkg::TickWidth-1:0]    r_tick, n_tick;
    logic [sprg_pkg::HoldWidth-1:0]    r_hold, n_hold;
    sprg_pkg::t_phase                  r_phase, n_phase;

    logic [sprg_pkg::CompareWidth-1:0] map_compare;
    logic [sprg_pkg::TickWidth-1:0]    tick_inc;
    logic                              busy;

    sprg_angle_map u_angle_map (
        .i_angle   (i_item.angle_deg),
        .o_compare (map_compare)
    );

    assign busy = (r_phase == sprg_pkg::PH_RAMP) || (r_phase == sprg_pkg::PH_HOLD);
    assign tick_inc = r_tick + 1'b1;

    always_comb begin
        n_cur   = r_cur;
        n_goal  = r_goal;
        n_step  = r_step;
        n_tick  = r_tick;
        n_hold  = r_hold;
        n_phase = r_phase;
        if (i_apply) begin
            if (i_item.cmd == sprg_pkg::CMD_MOVE) begin
                if (!busy) begin
                    n_goal = map_compare;
                    n_step = i_item.step_size;
                    n_hold = i_item.hold_ms;
                    n_tick = '0;
                    if (i_item.step_size == '0) begin
                        n_cur   = map_compare;
                        n_phase = (i_item.hold_ms == '0) ? sprg_pkg::PH_IDLE
                                                         : sprg_pkg::PH_HOLD;
                    end else if (r_cur == map_compare) begin
                        n_phase = (i_item.hold_ms == '0) ? sprg_pkg::PH_IDLE
                                                         : sprg_pkg::PH_HOLD;
                    end else begin
                        n_cur   = sprg_pkg::f_take_step(r_cur, map_compare,
                                                        i_item.step_size);
                        n_phase = sprg_pkg::PH_RAMP;
                    end
                end
            end else begin
                case (r_phase)
                    sprg_pkg::PH_RAMP: begin
                        if (tick_inc >= sprg_pkg::STEP_TICKS) begin
                            n_tick = '0;
                            if (r_cur == r_goal) begin
                                n_phase = (r_hold == '0) ? sprg_pkg::PH_IDLE
                                                         : sprg_pkg::PH_HOLD;
                            end else begin
                                n_cur = sprg_pkg::f_take_step(r_cur, r_goal, r_step);
                            end
                        end else begin
                            n_tick = tick_inc;
                        end
                    end
                    sprg_pkg::PH_HOLD: begin
                        n_hold = r_hold - 1'b1;
                        if (n_hold == '0) begin
                            n_phase = sprg_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_result.pulse_compare = n_cur;
        o_result.busy_res      = (n_phase == sprg_pkg::PH_RAMP)
                              || (n_phase == sprg_pkg::PH_HOLD);
        o_result.rejected      = i_apply && (i_item.cmd == sprg_pkg::CMD_MOVE) && busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= sprg_pkg::MIN_COMPARE;
            r_goal  <= sprg_pkg::MIN_COMPARE;
            r_step  <= '0;
            r_tick  <= '0;
            r_hold  <= '0;
            r_phase <= sprg_pkg::PH_IDLE;
        end else begin
            r_cur   <= n_cur;
            r_goal  <= n_goal;
            r_step  <= n_step;
            r_tick  <= n_tick;
            r_hold  <= n_hold;
            r_phase <= n_phase;
        end
    end

endmodule

@@ hdl/sprg_checker.sv @@
module sprg_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [sprg_pkg::CompareWidth-1:0] o_pulse_compare,
    input logic                              o_busy_res,
    input logic                              o_rejected
);

    // a rejected move leaves the block busy
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_busy_res)
        else $error("rejected move reported while not busy");

    a_compare_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pulse_compare >= sprg_pkg::MIN_COMPARE)
                     && (o_pulse_compare <= sprg_pkg::MAX_COMPARE))
        else $error("pulse compare out of range");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_pulse_compare) && $stable(o_busy_res)
                                        && $stable(o_rejected))
        else $error("result changed while stalled");

endmodule

bind servo_pulse_ramp_generator_core sprg_checker u_sprg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_pulse_compare (o_pulse_compare),
    .o_busy_res      (o_busy_res),
    .o_rejected      (o_rejected)
);

@@ tb/servo_pulse_ramp_generator_core_test.sv @@
module servo_pulse_ramp_generator_core_test;

    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned SettleCycles  = 10;
    localparam int unsigned RandomPerPhase = 275;

    // servo state tracker and the queue of compare/busy/reject values it predicts
    class servo_ramp_scoreboard;
        logic [sprg_pkg::CompareWidth-1:0] cur_cmp;
        logic [sprg_pkg::CompareWidth-1:0] goal_cmp;
        logic [sprg_pkg::StepWidth-1:0]    ramp_amt;
        logic [sprg_pkg::TickWidth-1:0]    tick_cnt;
        logic [sprg_pkg::HoldWidth-1:0]    hold_left;
        sprg_pkg::t_phase                  phase;
        sprg_pkg::t_result                 expected_q[$];
        int unsigned                       mismatches;

        function new();
            cur_cmp    = sprg_pkg::MIN_COMPARE;
            goal_cmp   = sprg_pkg::MIN_COMPARE;
            ramp_amt   = '0;
            tick_cnt   = '0;
            hold_left  = '0;
            phase      = sprg_pkg::PH_IDLE;
            mismatches = 0;
        endfunction

        function bit is_busy();
            return phase == sprg_pkg::PH_RAMP || phase == sprg_pkg::PH_HOLD;
        endfunction

        function logic [sprg_pkg::CompareWidth-1:0] angle_to_compare(
            logic [sprg_pkg::AngleWidth-1:0] angle);
            int unsigned a;
            int unsigned v;
            a = (angle > sprg_pkg::MAX_ANGLE) ? sprg_pkg::MAX_ANGLE : angle;
            v = sprg_pkg::MIN_COMPARE
              + (a * (sprg_pkg::MAX_COMPARE - sprg_pkg::MIN_COMPARE)) / sprg_pkg::MAX_ANGLE;
            return v[sprg_pkg::CompareWidth-1:0];
        endfunction

        // saturating move of the compare value toward the goal
        function void move_one_step();
            if (cur_cmp < goal_cmp) begin
                cur_cmp = (goal_cmp - cur_cmp < ramp_amt) ? goal_cmp : cur_cmp + ramp_amt;
            end else if (cur_cmp > goal_cmp) begin
                cur_cmp = (cur_cmp - goal_cmp < ramp_amt) ? goal_cmp : cur_cmp - ramp_amt;
            end
        endfunction

        function void start_hold();
            tick_cnt = '0;
            phase = (hold_left == 0) ? sprg_pkg::PH_IDLE : sprg_pkg::PH_HOLD;
        endfunction

        function void note_input(sprg_pkg::t_item it);
            sprg_pkg::t_result want;
            logic              rej;
            rej = 1'b0;
            if (it.cmd == sprg_pkg::CMD_MOVE) begin
                if (is_busy()) begin
                    rej = 1'b1;
                end else begin
                    goal_cmp  = angle_to_compare(it.angle_deg);
                    ramp_amt  = it.step_size;
                    hold_left = it.hold_ms;
                    tick_cnt  = '0;
                    if (it.step_size == 0) begin
                        cur_cmp = goal_cmp;
                        start_hold();
                    end else if (cur_cmp == goal_cmp) begin
                        start_hold();
                    end else begin
                        move_one_step();
                        phase = sprg_pkg::PH_RAMP;
                    end
                end
            end else if (phase == sprg_pkg::PH_RAMP) begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= sprg_pkg::STEP_TICKS) begin
                    tick_cnt = '0;
                    if (cur_cmp == goal_cmp) begin
                        start_hold();
                    end else begin
                        move_one_step();
                    end
                end
            end else if (phase == sprg_pkg::PH_HOLD) begin
                hold_left = hold_left - 1'b1;
                if (hold_left == 0) begin
                    phase = sprg_pkg::PH_IDLE;
                end
            end
            want.pulse_compare = cur_cmp;
            want.busy_res      = is_busy();
            want.rejected      = rej;
            expected_q.push_back(want);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(sprg_pkg::t_result got);
            sprg_pkg::t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result compare=%0d busy=%0b rejected=%0b",
                                 got.pulse_compare, got.busy_res, got.rejected));
                return;
            end
            want = expected_q.pop_front();
            if (got.pulse_compare !== want.pulse_compare) begin
                report($sformatf("pulse_compare got %0d want %0d",
                                 got.pulse_compare, want.pulse_compare));
            end
            if (got.busy_res !== want.busy_res) begin
                report($sformatf("busy_res got %0b want %0b", got.busy_res, want.busy_res));
            end
            if (got.rejected !== want.rejected) begin
                report($sformatf("rejected got %0b want %0b", got.rejected, want.rejected));
            end
        endtask
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_ready;
    logic                              move_bit;
    logic [sprg_pkg::AngleWidth-1:0]   angle;
    logic [sprg_pkg::HoldWidth-1:0]    hold;
    logic [sprg_pkg::StepWidth-1:0]    step;
    logic                              out_valid;
    logic                              out_ready;
    logic [sprg_pkg::CompareWidth-1:0] pulse_compare;
    logic                              busy_flag;
    logic                              rejected_flag;

    int unsigned                       in_idle_pct;
    int unsigned                       out_stall_pct;
    int unsigned                       stall_cycles = 0;
    logic [sprg_pkg::AngleWidth-1:0]   last_angle;

    servo_ramp_scoreboard sb = new();

    servo_pulse_ramp_generator_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_cmd           (move_bit),
        .i_angle_deg     (angle),
        .i_hold_ms       (hold),
        .i_step_size     (step),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_pulse_compare (pulse_compare),
        .o_busy_res      (busy_flag),
        .o_rejected      (rejected_flag)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        out_ready <= (out_stall_pct != 0 && $urandom_range(99) < out_stall_pct) ? 1'b0 : 1'b1;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_result(sprg_pkg::t_result'{pulse_compare, busy_flag, rejected_flag});
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WatchdogLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic sprg_pkg::t_item make_item(logic c,
                                                  logic [sprg_pkg::AngleWidth-1:0] a,
                                                  logic [sprg_pkg::HoldWidth-1:0] h,
                                                  logic [sprg_pkg::StepWidth-1:0] s);
        sprg_pkg::t_item it;
        it.cmd       = c;
        it.angle_deg = a;
        it.hold_ms   = h;
        it.step_size = s;
        return it;
    endfunction

    // tick with garbage in the ignored fields
    function automatic sprg_pkg::t_item tick_item();
        return make_item(sprg_pkg::CMD_TICK, sprg_pkg::AngleWidth'($urandom),
                         sprg_pkg::HoldWidth'($urandom), sprg_pkg::StepWidth'($urandom));
    endfunction

    function automatic sprg_pkg::t_item noise_item();
        return make_item($urandom_range(1), sprg_pkg::AngleWidth'($urandom),
                         sprg_pkg::HoldWidth'($urandom_range(1023)),
                         sprg_pkg::StepWidth'($urandom));
    endfunction

    function automatic sprg_pkg::t_item rand_move();
        int                             a;
        int unsigned                    r;
        logic [sprg_pkg::StepWidth-1:0] s;
        logic [sprg_pkg::HoldWidth-1:0] h;
        r = $urandom_range(99);
        if (r < 40) begin
            // short move near the last angle, any step size
            a = int'(last_angle) + int'($urandom_range(8)) - 4;
            if (a < 0) a = 0;
            if (a > 255) a = 255;
            s = sprg_pkg::StepWidth'($urandom_range(255));
        end else begin
            a = $urandom_range(255);
            s = ($urandom_range(99) < 20) ? '0 : sprg_pkg::StepWidth'($urandom_range(255, 64));
        end
        r = $urandom_range(99);
        if (r < 25) begin
            h = '0;
        end else if (r < 90) begin
            h = sprg_pkg::HoldWidth'($urandom_range(20, 1));
        end else begin
            h = sprg_pkg::HoldWidth'($urandom_range(400, 21));
        end
        return make_item(sprg_pkg::CMD_MOVE, sprg_pkg::AngleWidth'(a), h, s);
    endfunction

    task automatic send_item(input sprg_pkg::t_item it);
        int unsigned gap;
        gap = 0;
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        move_bit <= it.cmd;
        angle    <= it.angle_deg;
        hold     <= it.hold_ms;
        step     <= it.step_size;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(it);
        @(negedge clk);
    endtask

    task automatic tick_until_idle();
        while (sb.is_busy()) send_item(tick_item());
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
    endtask

    task automatic run_directed();
        send_item(tick_item());
        // already home, never busy
        send_item(make_item(sprg_pkg::CMD_MOVE, 8'd0, 16'd0, 8'd0));
        // clamped jump to full travel
        send_item(make_item(sprg_pkg::CMD_MOVE, 8'hFF, 16'd0, 8'd0));
        // jump with a short hold
        send_item(make_item(sprg_pkg::CMD_MOVE, 8'd181, 16'd2, 8'd0));
        // refused while holding
        send_item(make_item(sprg_pkg::CMD_MOVE, 8'd0, 16'd5, 8'd9));
        tick_until_idle();
        // widest step, no hold
        send_item(make_item(sprg_pkg::CMD_MOVE, 8'd0, 16'd0, 8'hFF));
        tick_until_idle();
        // at goal: hold at once
        send_item(make_item(sprg_pkg::CMD_MOVE, 8'd0, 16'd3, 8'd5));
        tick_until_idle();
        // last step lands short
        send_item(make_item(sprg_pkg::CMD_MOVE, 8'd9, 16'd1, 8'd7));
        tick_until_idle();
        // long hold, then a refused move with the largest fields
        send_item(make_item(sprg_pkg::CMD_MOVE, 8'd180, 16'd100, 8'd0));
        send_item(make_item(sprg_pkg::CMD_MOVE, 8'hFF, 16'hFFFF, 8'hFF));
        tick_until_idle();
        // first step overshoots
        send_item(make_item(sprg_pkg::CMD_MOVE, 8'd170, 16'd0, 8'hFF));
        tick_until_idle();
        last_angle = 8'd170;
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned     sent;
        int unsigned     r;
        int unsigned     budget;
        bit              was_idle;
        sprg_pkg::t_item mv;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 10) begin
                send_item(noise_item());
                sent++;
            end else begin
                mv = rand_move();
                was_idle = !sb.is_busy();
                send_item(mv);
                sent++;
                if (was_idle) last_angle = mv.angle_deg;
                // some sequences are cut short so the next move lands while busy
                budget = (r < 20) ? $urandom_range(30, 1) : 2000;
                while (sb.is_busy() && budget != 0 && sent < n_items) begin
                    if ($urandom_range(99) < 3) begin
                        send_item(rand_move());
                    end else begin
                        send_item(tick_item());
                    end
                    sent++;
                    budget--;
                end
            end
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        move_bit      = sprg_pkg::CMD_TICK;
        angle         = '0;
        hold          = '0;
        step          = '0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        last_angle    = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(RandomPerPhase);
        wait_results_drained();

        in_idle_pct = 81;
        run_random(RandomPerPhase);
        wait_results_drained();

        in_idle_pct   = 0;
        out_stall_pct = 81;
        run_random(RandomPerPhase);
        wait_results_drained();

        in_idle_pct   = 36;
        out_stall_pct = 36;
        run_random(RandomPerPhase);
        wait_results_drained();

        repeat (SettleCycles) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
